// ----- src/assert_macros.svh -----
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is low.
`define KCD_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("kcd assertion failed");

// Checked on every edge, reset included.
`define KCD_ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("kcd assertion failed");

`endif

// ----- src/kcd_pkg.sv -----
package kcd_pkg;

   // Field widths
   localparam int HOUR_W  = 5;
   localparam int COUNT_W = 4;
   localparam int TICK_W  = 16;

   // Configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_ENABLE         = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_OPEN_FROM_HOUR  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_OPEN_UNTIL_HOUR = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRESSES_NEEDED  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_TICKS    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_DOOR_TICKS      = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_BUZZER_TICKS    = 3'd6;

   // Register reset values
   localparam logic [HOUR_W-1:0]  RST_OPEN_FROM_HOUR  = 5'd8;
   localparam logic [HOUR_W-1:0]  RST_OPEN_UNTIL_HOUR = 5'd18;
   localparam logic [COUNT_W-1:0] RST_PRESSES_NEEDED  = 4'd4;
   localparam logic [TICK_W-1:0]  RST_TICKS           = 16'd3000;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
   localparam logic [TICK_W-1:0]  TICK_MAX  = '1;

   typedef enum logic [1:0] {
      MODE_IDLE,
      MODE_COUNT,
      MODE_DOOR,
      MODE_BUZZ
   } mode_type;

   typedef struct packed {
      logic               enable;
      logic [HOUR_W-1:0]  open_from_hour;
      logic [HOUR_W-1:0]  open_until_hour;
      logic [COUNT_W-1:0] presses_needed;
      logic [TICK_W-1:0]  window_ticks;
      logic [TICK_W-1:0]  door_pulse_ticks;
      logic [TICK_W-1:0]  buzzer_pulse_ticks;
   } cfg_type;

   typedef struct packed {
      logic               door_drive;
      logic               buzzer_drive;
      logic [COUNT_W-1:0] press_count;
   } result_type;

endpackage

// ----- src/kcd_if.sv -----
// Request channel: one tick sample per request
interface kcd_req_if;
   logic                       valid;
   logic                       ready;
   logic                       buzz_level;
   logic [kcd_pkg::HOUR_W-1:0] hour_now;

   modport source (output valid, output buzz_level, output hour_now, input ready);
   modport sink   (input valid, input buzz_level, input hour_now, output ready);
endinterface

// Result channel: one result per tick
interface kcd_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        door_drive;
   logic                        buzzer_drive;
   logic [kcd_pkg::COUNT_W-1:0] press_count;

   modport source (output valid, output door_drive, output buzzer_drive,
                   output press_count, input ready);
   modport sink   (input valid, input door_drive, input buzzer_drive,
                   input press_count, output ready);
endinterface

// ----- src/knock_code_door_opener_core.sv -----
// An accepted request passes the input register and then the result register before its
// result is valid; a stalled result can hold it in the input register in between.
// Throughput: one request per cycle when not stalled; a stalled result holds the input
// register and request ready follows result ready in the same cycle, so no bubble opens.
// Reset: synchronous, active high; clears sequencer state and pipeline
// valids, and returns all configuration registers to their default values.
`include "assert_macros.svh"

module knock_code_door_opener_core (
   input  logic                             clock,
   input  logic                             reset,
   kcd_req_if.sink                          req_bus,
   kcd_rsp_if.source                        rsp_bus,
   input  logic                             csr_we,
   input  logic [kcd_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [kcd_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   kcd_pkg::cfg_type             cfg;
   kcd_pkg::result_type          step_result;
   kcd_pkg::result_type          out_ff;
   logic                         in_valid_ff;
   logic                         out_valid_ff;
   logic                         in_buzz_ff;
   logic [kcd_pkg::HOUR_W-1:0]   in_hour_ff;
   logic                         advance;
   logic                         req_take;

   kcd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Stage handshake: input reg moves on when the result reg is free
   assign advance      = in_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || advance;
   assign req_take     = req_bus.valid && req_bus.ready;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         in_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_buzz_ff <= req_bus.buzz_level;
         in_hour_ff <= req_bus.hour_now;
      end
   end

   kcd_step u_step (
      .clock      (clock),
      .reset      (reset),
      .step_go    (advance),
      .buzz_level (in_buzz_ff),
      .hour_now   (in_hour_ff),
      .cfg        (cfg),
      .result     (step_result)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= step_result;
      end
   end

   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.door_drive   = out_ff.door_drive;
   assign rsp_bus.buzzer_drive = out_ff.buzzer_drive;
   assign rsp_bus.press_count  = out_ff.press_count;

   // A processed request always lands in the result register
   `KCD_ASSERT(a_advance_fills, clock, reset, advance |=> out_valid_ff)
   // A request held in the input stage is not dropped while stalled
   `KCD_ASSERT(a_input_holds, clock, reset, (in_valid_ff && !advance) |=> in_valid_ff)
   // The input stage never advances into a full, stalled result register
   `KCD_ASSERT(a_no_overrun, clock, reset, (out_valid_ff && !rsp_bus.ready) |-> !advance)

endmodule

// ----- src/kcd_csr.sv -----
module kcd_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [kcd_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [kcd_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output kcd_pkg::cfg_type                  cfg
);

   kcd_pkg::cfg_type cfg_ff;
   kcd_pkg::cfg_type cfg_in;

   // Register write decode; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            kcd_pkg::CSR_ENABLE:          cfg_in.enable = csr_wdata[0];
            kcd_pkg::CSR_OPEN_FROM_HOUR:
               cfg_in.open_from_hour = csr_wdata[kcd_pkg::HOUR_W-1:0];
            kcd_pkg::CSR_OPEN_UNTIL_HOUR:
               cfg_in.open_until_hour = csr_wdata[kcd_pkg::HOUR_W-1:0];
            kcd_pkg::CSR_PRESSES_NEEDED:
               cfg_in.presses_needed = csr_wdata[kcd_pkg::COUNT_W-1:0];
            kcd_pkg::CSR_WINDOW_TICKS:
               cfg_in.window_ticks = csr_wdata[kcd_pkg::TICK_W-1:0];
            kcd_pkg::CSR_DOOR_TICKS:
               cfg_in.door_pulse_ticks = csr_wdata[kcd_pkg::TICK_W-1:0];
            kcd_pkg::CSR_BUZZER_TICKS:
               cfg_in.buzzer_pulse_ticks = csr_wdata[kcd_pkg::TICK_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable             <= 1'b0;
         cfg_ff.open_from_hour     <= kcd_pkg::RST_OPEN_FROM_HOUR;
         cfg_ff.open_until_hour    <= kcd_pkg::RST_OPEN_UNTIL_HOUR;
         cfg_ff.presses_needed     <= kcd_pkg::RST_PRESSES_NEEDED;
         cfg_ff.window_ticks       <= kcd_pkg::RST_TICKS;
         cfg_ff.door_pulse_ticks   <= kcd_pkg::RST_TICKS;
         cfg_ff.buzzer_pulse_ticks <= kcd_pkg::RST_TICKS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- src/kcd_step.sv -----
`include "assert_macros.svh"

module kcd_step (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step_go,
   input  logic                          buzz_level,
   input  logic [kcd_pkg::HOUR_W-1:0]    hour_now,
   input  kcd_pkg::cfg_type              cfg,
   output kcd_pkg::result_type           result
);

   kcd_pkg::mode_type             mode_ff, mode_in;
   logic [kcd_pkg::TICK_W-1:0]    window_timer_ff, window_timer_in;
   logic [kcd_pkg::TICK_W-1:0]    pulse_timer_ff, pulse_timer_in;
   logic [kcd_pkg::COUNT_W-1:0]   presses_seen_ff, presses_seen_in;
   logic                          held_ff, held_in;
   logic                          free_entry;
   logic                          win_done;

   // Free entry only strictly inside the hour window
   assign free_entry = (hour_now > cfg.open_from_hour) && (hour_now < cfg.open_until_hour);

   // Next state for one tick
   always_comb begin
      mode_in         = mode_ff;
      window_timer_in = window_timer_ff;
      pulse_timer_in  = pulse_timer_ff;
      presses_seen_in = presses_seen_ff;
      held_in         = held_ff;
      win_done        = 1'b0;

      case (mode_ff)
         kcd_pkg::MODE_IDLE: begin
            if (cfg.enable && buzz_level) begin
               if (free_entry) begin
                  mode_in        = kcd_pkg::MODE_DOOR;
                  pulse_timer_in = (cfg.door_pulse_ticks == '0) ? kcd_pkg::TICK_W'(1)
                                                                : cfg.door_pulse_ticks;
               end else begin
                  mode_in         = kcd_pkg::MODE_COUNT;
                  window_timer_in = '0;
                  presses_seen_in = '0;
                  held_in         = 1'b1;
               end
            end
         end
         kcd_pkg::MODE_COUNT: begin
            if (window_timer_ff != kcd_pkg::TICK_MAX) begin
               window_timer_in = window_timer_ff + kcd_pkg::TICK_W'(1);
            end
            if (buzz_level) begin
               held_in = 1'b1;
            end else begin
               // count on release, saturating
               if (held_ff) begin
                  if (presses_seen_ff != kcd_pkg::COUNT_MAX) begin
                     presses_seen_in = presses_seen_ff + kcd_pkg::COUNT_W'(1);
                  end
                  held_in = 1'b0;
               end
               win_done = (window_timer_in >= cfg.window_ticks);
               if (win_done) begin
                  if (presses_seen_in == cfg.presses_needed) begin
                     mode_in        = kcd_pkg::MODE_DOOR;
                     pulse_timer_in = (cfg.door_pulse_ticks == '0) ? kcd_pkg::TICK_W'(1)
                                                                   : cfg.door_pulse_ticks;
                  end else begin
                     mode_in        = kcd_pkg::MODE_BUZZ;
                     pulse_timer_in = (cfg.buzzer_pulse_ticks == '0) ? kcd_pkg::TICK_W'(1)
                                                                     : cfg.buzzer_pulse_ticks;
                  end
               end
            end
         end
         default: ;
      endcase

      // Pulse phase, including a pulse started on this tick
      result.door_drive   = (mode_in == kcd_pkg::MODE_DOOR);
      result.buzzer_drive = (mode_in == kcd_pkg::MODE_BUZZ);
      if (result.door_drive || result.buzzer_drive) begin
         if (pulse_timer_in != '0) begin
            pulse_timer_in = pulse_timer_in - kcd_pkg::TICK_W'(1);
         end
         if (pulse_timer_in == '0) begin
            mode_in = kcd_pkg::MODE_IDLE;
         end
      end
      result.press_count = presses_seen_in;
   end

   // State registers advance once per tick
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= kcd_pkg::MODE_IDLE;
         window_timer_ff <= '0;
         pulse_timer_ff  <= '0;
         presses_seen_ff <= '0;
         held_ff         <= 1'b0;
      end else if (step_go) begin
         mode_ff         <= mode_in;
         window_timer_ff <= window_timer_in;
         pulse_timer_ff  <= pulse_timer_in;
         presses_seen_ff <= presses_seen_in;
         held_ff         <= held_in;
      end
   end

   // A pulse in progress always has ticks left
   `KCD_ASSERT(a_pulse_timer_live, clock, reset,
      (mode_ff == kcd_pkg::MODE_DOOR || mode_ff == kcd_pkg::MODE_BUZZ) |-> pulse_timer_ff != '0)
   // Door and buzzer are never driven together
   `KCD_ASSERT(a_drive_exclusive, clock, reset, !(result.door_drive && result.buzzer_drive))
   // Reset returns the sequencer to idle
   `KCD_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> mode_ff == kcd_pkg::MODE_IDLE)

endmodule

// ----- tb/knock_code_door_opener_core_tb.sv -----
module knock_code_door_opener_core_tb;
   import kcd_pkg::*;

   localparam int CYCLE_LIMIT  = 3_000_000;
   localparam int DRAIN_CYCLES = 4;
   localparam int MAX_NOTES    = 30;
   // index past the last register; writes to it must change nothing
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 3'd7;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   kcd_req_if req_if();
   kcd_rsp_if rsp_if();

   knock_code_door_opener_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_if),
      .rsp_bus   (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // predicted registers and sequencer state
   cfg_type             regs;
   mode_type            door_mode;
   logic [TICK_W-1:0]   win_timer;
   logic [TICK_W-1:0]   pulse_left;
   logic [COUNT_W-1:0]  presses;
   logic                held;

   result_type predicted_outputs[$];

   int  errors;
   int  requests_sent;
   int  results_seen;
   int  door_ticks;
   int  buzz_ticks;
   int  cycle_count;
   bit  sender_idles;
   bit  receiver_stalls;

   function automatic void reset_opener();
      regs.enable             = 1'b0;
      regs.open_from_hour     = RST_OPEN_FROM_HOUR;
      regs.open_until_hour    = RST_OPEN_UNTIL_HOUR;
      regs.presses_needed     = RST_PRESSES_NEEDED;
      regs.window_ticks       = RST_TICKS;
      regs.door_pulse_ticks   = RST_TICKS;
      regs.buzzer_pulse_ticks = RST_TICKS;
      door_mode  = MODE_IDLE;
      win_timer  = '0;
      pulse_left = '0;
      presses    = '0;
      held       = 1'b0;
   endfunction

   function automatic void apply_reg(logic [CSR_INDEX_W-1:0] idx,
                                     logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_ENABLE:          regs.enable             = data[0];
         CSR_OPEN_FROM_HOUR:  regs.open_from_hour     = data[HOUR_W-1:0];
         CSR_OPEN_UNTIL_HOUR: regs.open_until_hour    = data[HOUR_W-1:0];
         CSR_PRESSES_NEEDED:  regs.presses_needed     = data[COUNT_W-1:0];
         CSR_WINDOW_TICKS:    regs.window_ticks       = data[TICK_W-1:0];
         CSR_DOOR_TICKS:      regs.door_pulse_ticks   = data[TICK_W-1:0];
         CSR_BUZZER_TICKS:    regs.buzzer_pulse_ticks = data[TICK_W-1:0];
         default: ;
      endcase
   endfunction

   // zero length behaves as one tick
   function automatic void begin_pulse(mode_type which, logic [TICK_W-1:0] len);
      door_mode  = which;
      pulse_left = (len == '0) ? TICK_W'(1) : len;
   endfunction

   // one tick of the opener: advances the predicted state, returns the outputs
   function automatic result_type opener_tick(logic level, logic [HOUR_W-1:0] hour);
      result_type r;
      r = '0;
      case (door_mode)
         MODE_IDLE: begin
            if (regs.enable && level) begin
               if (hour > regs.open_from_hour && hour < regs.open_until_hour) begin
                  begin_pulse(MODE_DOOR, regs.door_pulse_ticks);
               end else begin
                  door_mode = MODE_COUNT;
                  win_timer = '0;
                  presses   = '0;
                  held      = 1'b1;
               end
            end
         end
         MODE_COUNT: begin
            if (win_timer != TICK_MAX) win_timer = win_timer + 1'b1;
            if (level) begin
               held = 1'b1;
            end else begin
               // presses count on release
               if (held) begin
                  if (presses != COUNT_MAX) presses = presses + 1'b1;
                  held = 1'b0;
               end
               if (win_timer >= regs.window_ticks) begin
                  if (presses == regs.presses_needed)
                     begin_pulse(MODE_DOOR, regs.door_pulse_ticks);
                  else
                     begin_pulse(MODE_BUZZ, regs.buzzer_pulse_ticks);
               end
            end
         end
         default: ;
      endcase
      // a pulse drives on the tick it starts
      if (door_mode == MODE_DOOR || door_mode == MODE_BUZZ) begin
         r.door_drive   = (door_mode == MODE_DOOR);
         r.buzzer_drive = (door_mode == MODE_BUZZ);
         if (pulse_left != '0) pulse_left = pulse_left - 1'b1;
         if (pulse_left == '0) door_mode = MODE_IDLE;
      end
      r.press_count = presses;
      return r;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      errors++;
      if (errors <= MAX_NOTES)
         $display("mismatch at result %0d: %s got %0d expected %0d",
                  results_seen, what, got, want);
   endtask

   // result checker and receiver stalls
   always @(posedge clock) begin : check_results
      result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (predicted_outputs.size() == 0) begin
            report_mismatch("result with no request pending", 1, 0);
         end else begin
            want = predicted_outputs.pop_front();
            if (rsp_if.door_drive !== want.door_drive)
               report_mismatch("door_drive", rsp_if.door_drive, want.door_drive);
            if (rsp_if.buzzer_drive !== want.buzzer_drive)
               report_mismatch("buzzer_drive", rsp_if.buzzer_drive, want.buzzer_drive);
            if (rsp_if.press_count !== want.press_count)
               report_mismatch("press_count", rsp_if.press_count, want.press_count);
            if (want.door_drive) door_ticks++;
            if (want.buzzer_drive) buzz_ticks++;
         end
         results_seen++;
      end
      rsp_if.ready <= receiver_stalls ? ($urandom_range(99) >= 24) : 1'b1;
   end

   // watchdog
   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILURE");
      $finish;
   end

   // one tick request; valid stays high for a back-to-back request
   task automatic send_tick(logic level, logic [HOUR_W-1:0] hour);
      while (sender_idles && $urandom_range(99) < 24) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.buzz_level <= level;
      req_if.hour_now   <= hour;
      @(posedge clock);
      while (!(req_if.valid && req_if.ready)) @(posedge clock);
      predicted_outputs.push_back(opener_tick(level, hour));
      requests_sent++;
   endtask

   // stop sending and let every pending result drain
   task automatic quiesce();
      req_if.valid <= 1'b0;
      while (predicted_outputs.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_put(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      apply_reg(idx, data);
      @(posedge clock);
   endtask

   task automatic csr_end();
      csr_we <= 1'b0;
   endtask

   task automatic program_regs(cfg_type c);
      quiesce();
      csr_put(CSR_ENABLE,          CSR_DATA_W'(c.enable));
      csr_put(CSR_OPEN_FROM_HOUR,  CSR_DATA_W'(c.open_from_hour));
      csr_put(CSR_OPEN_UNTIL_HOUR, CSR_DATA_W'(c.open_until_hour));
      csr_put(CSR_PRESSES_NEEDED,  CSR_DATA_W'(c.presses_needed));
      csr_put(CSR_WINDOW_TICKS,    c.window_ticks);
      csr_put(CSR_DOOR_TICKS,      c.door_pulse_ticks);
      csr_put(CSR_BUZZER_TICKS,    c.buzzer_pulse_ticks);
      csr_end();
   endtask

   function automatic cfg_type make_cfg(logic en, int from_hr, int until_hr, int needed,
                                        int window, int door, int buzz);
      cfg_type c;
      c.enable             = en;
      c.open_from_hour     = HOUR_W'(from_hr);
      c.open_until_hour    = HOUR_W'(until_hr);
      c.presses_needed     = COUNT_W'(needed);
      c.window_ticks       = TICK_W'(window);
      c.door_pulse_ticks   = TICK_W'(door);
      c.buzzer_pulse_ticks = TICK_W'(buzz);
      return c;
   endfunction

   // mostly real hours, sometimes the raw values past 23
   function automatic logic [HOUR_W-1:0] rand_hour();
      if ($urandom_range(7) == 0) return HOUR_W'($urandom_range(24, 31));
      return HOUR_W'($urandom_range(0, 23));
   endfunction

   task automatic knock_burst(logic [HOUR_W-1:0] hour, int count);
      for (int i = 0; i < count; i++) begin
         repeat ($urandom_range(1, 3)) send_tick(1'b1, hour);
         repeat ($urandom_range(1, 2)) send_tick(1'b0, hour);
      end
   endtask

   // reset values: disabled, then default hours and press count
   task automatic test_defaults();
      send_tick(1'b1, 5'd12);
      send_tick(1'b1, 5'd12);
      quiesce();
      csr_put(CSR_ENABLE, 16'd1);
      csr_end();
      // hour equal to the default start hour is outside free entry
      send_tick(1'b1, RST_OPEN_FROM_HOUR);
      send_tick(1'b0, RST_OPEN_FROM_HOUR);
      quiesce();
      csr_put(CSR_WINDOW_TICKS, 16'd1);
      csr_put(CSR_BUZZER_TICKS, 16'd1);
      csr_end();
      // one press against four needed rings the buzzer
      send_tick(1'b0, RST_OPEN_FROM_HOUR);
      send_tick(1'b0, RST_OPEN_FROM_HOUR);
   endtask

   // free-entry hours, both bounds exclusive, inverted and raw hours
   task automatic test_free_entry();
      program_regs(make_cfg(1'b1, 5, 9, 1, 1, 2, 1));
      send_tick(1'b1, 5'd6);
      send_tick(1'b1, 5'd6);
      send_tick(1'b1, 5'd9);
      send_tick(1'b0, 5'd9);
      send_tick(1'b0, 5'd9);
      send_tick(1'b1, 5'd5);
      send_tick(1'b0, 5'd5);
      send_tick(1'b0, 5'd0);
      program_regs(make_cfg(1'b1, 20, 4, 1, 1, 1, 1));
      send_tick(1'b1, 5'd22);
      send_tick(1'b0, 5'd22);
      send_tick(1'b1, 5'd2);
      send_tick(1'b0, 5'd2);
      program_regs(make_cfg(1'b1, 24, 31, 1, 1, 1, 1));
      send_tick(1'b1, 5'd30);
      send_tick(1'b1, 5'd31);
      send_tick(1'b0, 5'd31);
   endtask

   // zero lengths act as one tick
   task automatic test_zero_lengths();
      program_regs(make_cfg(1'b1, 10, 14, 1, 0, 0, 0));
      send_tick(1'b1, 5'd12);
      send_tick(1'b1, 5'd12);
      send_tick(1'b1, 5'd3);
      send_tick(1'b0, 5'd3);
      send_tick(1'b1, 5'd3);
      send_tick(1'b1, 5'd3);
      send_tick(1'b0, 5'd3);
      send_tick(1'b0, 5'd3);
   endtask

   // press count saturates at its maximum
   task automatic test_press_saturation();
      program_regs(make_cfg(1'b1, 0, 0, 15, 40, 1, 1));
      repeat (20) begin
         send_tick(1'b1, 5'd0);
         send_tick(1'b0, 5'd0);
      end
      repeat (3) send_tick(1'b0, 5'd0);
   endtask

   // a running window completes after enable drops; unused index is ignored
   task automatic test_enable_drop();
      program_regs(make_cfg(1'b1, 0, 0, 2, 3, 1, 1));
      send_tick(1'b1, 5'd3);
      send_tick(1'b0, 5'd3);
      quiesce();
      csr_put(CSR_ENABLE, 16'd0);
      csr_put(CSR_UNUSED, 16'hFFFF);
      csr_end();
      send_tick(1'b1, 5'd3);
      send_tick(1'b0, 5'd3);
      send_tick(1'b1, 5'd3);
      send_tick(1'b0, 5'd3);
   endtask

   // longer window and pulses, a press held past the window end, no idling
   task automatic test_long_timers();
      sender_idles    = 1'b0;
      receiver_stalls = 1'b0;
      program_regs(make_cfg(1'b1, 0, 0, 1, 20, 24, 18));
      send_tick(1'b1, 5'd5);
      repeat (24) send_tick(1'b1, 5'd5);
      repeat (26) send_tick(1'b0, 5'd5);
      quiesce();
      csr_put(CSR_WINDOW_TICKS, 16'd1);
      csr_put(CSR_PRESSES_NEEDED, 16'd2);
      csr_end();
      send_tick(1'b1, 5'd5);
      repeat (20) send_tick(1'b0, 5'd5);
      sender_idles    = 1'b1;
      receiver_stalls = 1'b1;
   endtask

   // random settings, mostly well-formed knock sequences plus noise
   task automatic test_random_phase(int count);
      cfg_type            c;
      int                 first;
      int                 tail;
      logic [HOUR_W-1:0]  hr;
      c.enable             = ($urandom_range(9) != 0);
      c.open_from_hour     = rand_hour();
      c.open_until_hour    = rand_hour();
      c.presses_needed     = ($urandom_range(7) == 0) ? COUNT_W'($urandom_range(0, 15))
                                                      : COUNT_W'($urandom_range(0, 4));
      c.window_ticks       = TICK_W'($urandom_range(0, 12));
      c.door_pulse_ticks   = TICK_W'($urandom_range(0, 5));
      c.buzzer_pulse_ticks = TICK_W'($urandom_range(0, 5));
      program_regs(c);
      first = requests_sent;
      while (requests_sent - first < count) begin
         if ($urandom_range(4) == 0) begin
            repeat ($urandom_range(1, 8)) send_tick(1'($urandom_range(1)), rand_hour());
         end else begin
            hr = rand_hour();
            repeat ($urandom_range(0, 2)) send_tick(1'b0, hr);
            knock_burst(hr, $urandom_range(1, int'(c.presses_needed) + 2));
            tail = int'(c.window_ticks) + int'(c.door_pulse_ticks)
                 + int'(c.buzzer_pulse_ticks) + $urandom_range(0, 3);
            repeat (tail) send_tick(1'b0, hr);
         end
      end
   endtask

   initial begin
      reset           = 1'b1;
      csr_we          = 1'b0;
      csr_index       = '0;
      csr_wdata       = '0;
      req_if.valid      = 1'b0;
      req_if.buzz_level = 1'b0;
      req_if.hour_now   = '0;
      rsp_if.ready      = 1'b0;
      sender_idles    = 1'b1;
      receiver_stalls = 1'b1;
      reset_opener();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_defaults();
      test_free_entry();
      test_zero_lengths();
      test_press_saturation();
      test_enable_drop();
      test_long_timers();
      repeat (5) test_random_phase(90);
      quiesce();

      $display("covered %0d requests and %0d results (%0d door ticks, %0d buzzer ticks)",
               requests_sent, results_seen, door_ticks, buzz_ticks);
      $display("settings: reset values, hour bounds, zero and longer lengths, random");
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("%0d mismatches", errors);
         $display("FAILURE");
      end
      $finish;
   end

endmodule
